// ----- src/skfm_pkg.sv -----
// shared constants, types and state encodings for the multichannel scalar kalman filter
`timescale 1ns / 1ps
package skfm_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int DEFAULT_SLOTS = 4;

   localparam int SAMPLE_W    = 12;
   localparam int CHANNEL_W   = 3;
   localparam int NOISE_W     = 24;
   localparam int EST_W       = FRAC_BITS + 2;
   localparam int VAR_W       = 32;
   localparam int GAIN_W      = FRAC_BITS + 1;
   localparam int DEN_W       = VAR_W + 1;
   localparam int PROD_W      = GAIN_W + VAR_W;
   localparam int DIV_CNT_W   = $clog2(FRAC_BITS + 1);
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROCESS_NOISE     = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_NOISE = CSR_INDEX_W'(1);

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = NOISE_W'(524);
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = NOISE_W'(655360);
   localparam logic [EST_W-1:0]   WORKING_EST_RESET       = EST_W'(1) << FRAC_BITS;
   localparam logic [GAIN_W-1:0]  GAIN_ONE                = GAIN_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DEN,
      ST_DIV,
      ST_MUL_EST,
      ST_MUL_VAR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic den;
      logic div_step;
      logic div_first;
      logic mul_est;
      logic mul_var;
      logic commit;
   } cmd_type;

endpackage

// ----- src/skfm_req_if.sv -----
// request channel: one adc word with its channel number
`timescale 1ns / 1ps
interface skfm_req_if import skfm_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [SAMPLE_W-1:0]  sample;
   logic [CHANNEL_W-1:0] channel;

   modport source (output valid, output sample, output channel, input ready);
   modport sink   (input valid, input sample, input channel, output ready);
endinterface

// ----- src/skfm_rsp_if.sv -----
// response channel: one filtered estimate word
`timescale 1ns / 1ps
interface skfm_rsp_if import skfm_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [EST_W-1:0] estimate;

   modport source (output valid, output estimate, input ready);
   modport sink   (input valid, input estimate, output ready);
endinterface

// ----- src/skfm_datapath.sv -----
// filter datapath: noise registers, channel state, gain divider, shared multiplier
`timescale 1ns / 1ps
module skfm_datapath import skfm_pkg::*; #(
   parameter int CHANNEL_SLOTS = DEFAULT_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic [SAMPLE_W-1:0]    req_sample,
   input  logic [CHANNEL_W-1:0]   req_channel,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [NOISE_W-1:0]     csr_wdata,
   output logic [EST_W-1:0]       rsp_estimate
);

   localparam int IDX_W = (CHANNEL_SLOTS > 1) ? $clog2(CHANNEL_SLOTS) : 1;

   logic [NOISE_W-1:0] q_ff, q_in;
   logic [NOISE_W-1:0] r_ff, r_in;

   logic [EST_W-1:0] work_est_ff;
   logic [VAR_W-1:0] work_var_ff;
   logic [EST_W-1:0] slot_est_ff [CHANNEL_SLOTS];
   logic [VAR_W-1:0] slot_var_ff [CHANNEL_SLOTS];

   logic [EST_W-1:0]  x_ff, x_in;
   logic [VAR_W-1:0]  p_ff, p_in;
   logic [EST_W-1:0]  z_ff, z_in;
   logic              slotted_ff, slotted_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [VAR_W-1:0]  pp_ff, pp_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic              up_ff, up_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [EST_W-1:0]  x_new_ff, x_new_in;
   logic [EST_W-1:0]  rsp_est_ff, rsp_est_in;

   logic                   slotted;
   logic [IDX_W-1:0]       idx;
   logic [SAMPLE_W+1:0]    s3;
   logic [SAMPLE_W+1+FRAC_BITS:0] z_wide;
   logic [VAR_W:0]         pp_sum;
   logic [DEN_W:0]         trial;
   logic                   ge;
   logic [GAIN_W-1:0]      gain_eff;
   logic [EST_W-1:0]       diff;
   logic [GAIN_W-1:0]      mul_a;
   logic [VAR_W-1:0]       mul_b;
   logic [EST_W-1:0]       est_step;

   // channel decode and volts conversion (times 3, scaled by 2^frac / 4096)
   always_comb begin
      slotted = (req_channel != '0) && (32'(req_channel) <= 32'(CHANNEL_SLOTS));
      idx     = IDX_W'(req_channel - CHANNEL_W'(1));
      s3      = {2'b00, req_sample} + {1'b0, req_sample, 1'b0};
      z_wide  = {s3, {FRAC_BITS{1'b0}}};
   end

   always_comb begin
      pp_sum   = {1'b0, p_ff} + {{(VAR_W + 1 - NOISE_W){1'b0}}, q_ff};
      trial    = cmd.div_first ? {2'b00, pp_ff} : {rem_ff, 1'b0};
      ge       = trial >= {1'b0, den_ff};
      // zero denominator only with zero variance and zero noise: no update
      gain_eff = (den_ff == '0) ? '0 : gain_ff;
      diff     = up_ff ? (z_ff - x_ff) : (x_ff - z_ff);
      est_step = prod_ff[FRAC_BITS +: EST_W];
      if (cmd.mul_var) begin
         mul_a = GAIN_ONE - gain_eff;
         mul_b = pp_ff;
      end else begin
         mul_a = gain_eff;
         mul_b = VAR_W'(diff);
      end
   end

   always_comb begin
      q_in       = q_ff;
      r_in       = r_ff;
      x_in       = x_ff;
      p_in       = p_ff;
      z_in       = z_ff;
      slotted_in = slotted_ff;
      idx_in     = idx_ff;
      pp_in      = pp_ff;
      den_in     = den_ff;
      rem_in     = rem_ff;
      gain_in    = gain_ff;
      up_in      = up_ff;
      prod_in    = prod_ff;
      x_new_in   = x_new_ff;
      rsp_est_in = rsp_est_ff;

      if (csr_we) begin
         case (csr_index)
            CSR_PROCESS_NOISE:     q_in = csr_wdata;
            CSR_MEASUREMENT_NOISE: r_in = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         z_in       = z_wide[SAMPLE_W+1+FRAC_BITS -: EST_W];
         slotted_in = slotted;
         idx_in     = idx;
         x_in       = slotted ? slot_est_ff[idx] : work_est_ff;
         p_in       = slotted ? slot_var_ff[idx] : work_var_ff;
      end
      if (cmd.prep) begin
         pp_in = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
         up_in = z_ff >= x_ff;
      end
      if (cmd.den) begin
         den_in = {1'b0, pp_ff} + {{(DEN_W - NOISE_W){1'b0}}, r_ff};
      end
      if (cmd.div_step) begin
         rem_in  = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         gain_in = {gain_ff[GAIN_W-2:0], ge};
      end
      if (cmd.mul_est || cmd.mul_var) begin
         prod_in = {{(PROD_W - GAIN_W){1'b0}}, mul_a} * {{(PROD_W - VAR_W){1'b0}}, mul_b};
      end
      if (cmd.mul_var) begin
         x_new_in = up_ff ? (x_ff + est_step) : (x_ff - est_step);
      end
      if (cmd.commit) begin
         rsp_est_in = x_new_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff        <= PROCESS_NOISE_RESET;
         r_ff        <= MEASUREMENT_NOISE_RESET;
         work_est_ff <= WORKING_EST_RESET;
         work_var_ff <= '0;
         for (int i = 0; i < CHANNEL_SLOTS; i++) begin
            slot_est_ff[i] <= '0;
            slot_var_ff[i] <= '0;
         end
      end else begin
         q_ff <= q_in;
         r_ff <= r_in;
         if (cmd.commit) begin
            work_est_ff <= x_new_ff;
            work_var_ff <= prod_ff[FRAC_BITS +: VAR_W];
            if (slotted_ff) begin
               slot_est_ff[idx_ff] <= x_new_ff;
               slot_var_ff[idx_ff] <= prod_ff[FRAC_BITS +: VAR_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      p_ff       <= p_in;
      z_ff       <= z_in;
      slotted_ff <= slotted_in;
      idx_ff     <= idx_in;
      pp_ff      <= pp_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      gain_ff    <= gain_in;
      up_ff      <= up_in;
      prod_ff    <= prod_in;
      x_new_ff   <= x_new_in;
      rsp_est_ff <= rsp_est_in;
   end

   assign rsp_estimate = rsp_est_ff;

endmodule

// ----- src/skfm_ctrl.sv -----
// filter sequencer: handshake, step counting and output word valid
`timescale 1ns / 1ps
module skfm_ctrl import skfm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 div_last;
   logic                 out_free;

   assign div_last = cnt_ff == DIV_CNT_W'(FRAC_BITS);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: state_in = ST_DEN;
         ST_DEN: begin
            state_in = ST_DIV;
            cnt_in   = '0;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (div_last) state_in = ST_MUL_EST;
         end
         ST_MUL_EST: state_in = ST_MUL_VAR;
         ST_MUL_VAR: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_PREP: cmd.prep = 1'b1;
         ST_DEN:  cmd.den  = 1'b1;
         ST_DIV: begin
            cmd.div_step  = 1'b1;
            cmd.div_first = cnt_ff == '0;
         end
         ST_MUL_EST: cmd.mul_est = 1'b1;
         ST_MUL_VAR: cmd.mul_var = 1'b1;
         ST_FINISH:  cmd.commit  = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit)    rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_ready))
      else $error("word committed over a held output");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("committed word not presented");

   a_div_stays: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && !div_last) |=> (state_ff == ST_DIV))
      else $error("divider left early");

   a_load_prep: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_PREP && !req_ready))
      else $error("accepted word did not start the update");
`endif

endmodule

// ----- src/scalar_kalman_filter_multichannel.sv -----
// top level of the multichannel scalar kalman filter
//
// req_chan carries one 12-bit adc word and a channel number; channels 1 to
// CHANNEL_SLOTS each keep their own estimate and variance, channel 0 and
// unlisted codes continue from whatever the last update left behind.
// rsp_chan returns exactly one filtered estimate (volts, 16 fraction bits)
// per accepted word, in order. csr_we/csr_index/csr_wdata write process
// noise (index 0) and measurement noise (index 1); write only while idle.
// The update state machine steps through variance prediction, the
// denominator, the restoring gain divider (one quotient bit per cycle),
// the shared multiplier (estimate step, then variance) and the commit.
// rsp valid is registered and rises after the commit. A new word is
// not accepted before the last one commits; the next can be accepted in
// the cycle after the commit. A finished word waits in the output
// register while the receiver stalls; the next word can be accepted and
// computed meanwhile and only its commit waits for the register to empty.
// reset (synchronous, active high) loads the noise defaults, sets the
// working estimate to one volt and clears all variances and slot estimates.
`timescale 1ns / 1ps
module scalar_kalman_filter_multichannel import skfm_pkg::*; #(
   parameter int CHANNEL_SLOTS = DEFAULT_SLOTS
) (
   input  logic                   clock,
   input  logic                   reset,
   skfm_req_if.sink               req_chan,
   skfm_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [NOISE_W-1:0]     csr_wdata
);

   cmd_type cmd;

   skfm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   skfm_datapath #(
      .CHANNEL_SLOTS (CHANNEL_SLOTS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_sample   (req_chan.sample),
      .req_channel  (req_chan.channel),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .rsp_estimate (rsp_chan.estimate)
   );

endmodule
